// ----- hdl/pos_pkg.sv -----
// ----------------------------------------------------------------------------
// pos_pkg
// Shared types and constants for the power output supervisor.
// ----------------------------------------------------------------------------
package pos_pkg;

  localparam logic [2:0] OP_SAMPLE  = 3'd0;
  localparam logic [2:0] OP_ENABLE  = 3'd1;
  localparam logic [2:0] OP_DISABLE = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_REPORT  = 3'd4;

  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_ABS_OV   = 3'd1;
  localparam logic [2:0] FLT_TIMEOUT  = 3'd2;
  localparam logic [2:0] FLT_NO_INPUT = 3'd3;
  localparam logic [2:0] FLT_UV       = 3'd4;
  localparam logic [2:0] FLT_OV       = 3'd5;
  localparam logic [2:0] FLT_OC       = 3'd6;
  localparam logic [2:0] FLT_OT       = 3'd7;

  localparam logic [1:0] PH_OFF  = 2'd0;
  localparam logic [1:0] PH_SOFT = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  localparam int unsigned StableBandMv = 100;

endpackage

// ----- hdl/power_output_supervisor_core.sv -----
// ----------------------------------------------------------------------------
// power_output_supervisor_core
// Soft-start and run-time supervision of a switched power output.
// ----------------------------------------------------------------------------
// Every word except a report passes through the execute state and then the
// output state (S_OUT). A report with samples runs the three averages one after
// another through a single bit-serial divider, which sets how long a report
// takes; no new input word is taken until the result word has been accepted.
// Statistics sums are COUNT_BITS+16 bits wide.
module power_output_supervisor_core #(
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned TIME_BITS  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input word
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] voltage_mv_i,
  input  logic [15:0] current_ma_i,
  input  logic signed [11:0] temperature_dc_i,
  input  logic [15:0] delta_us_i,
  // result word
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        output_enabled_o,
  output logic [2:0]  fault_code_o,
  output logic [15:0] vmax_o,
  output logic [15:0] vmin_o,
  output logic [15:0] vmean_o,
  output logic [15:0] imax_o,
  output logic [15:0] imin_o,
  output logic [15:0] imean_o,
  output logic signed [11:0] tmax_o,
  output logic signed [11:0] tmin_o,
  output logic signed [11:0] tmean_o,
  output logic [19:0] sample_count_o
);
  import pos_pkg::*;

  localparam int unsigned SumBits = COUNT_BITS + 16;
  localparam logic [TIME_BITS-1:0] TimeMax = '1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // configuration registers
  logic [15:0] uvl_q, cl_q, uvlev_q, nil_q, amax_q;
  logic signed [11:0] tl_q;
  logic [19:0] win_q, tmo_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uvl_q <= 16'd17000; cl_q <= 16'd20000; tl_q <= 12'sd900;
      uvlev_q <= 16'd4500; nil_q <= 16'd1000; amax_q <= 16'd18000;
      win_q <= 20'd5000; tmo_q <= 20'd100000;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        3'd0: uvl_q <= pwdata[15:0];
        3'd1: cl_q <= pwdata[15:0];
        3'd2: tl_q <= pwdata[11:0];
        3'd3: uvlev_q <= pwdata[15:0];
        3'd4: nil_q <= pwdata[15:0];
        3'd5: amax_q <= pwdata[15:0];
        3'd6: win_q <= pwdata[19:0];
        3'd7: tmo_q <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      3'd0: prdata = {16'd0, uvl_q};
      3'd1: prdata = {16'd0, cl_q};
      3'd2: prdata = {{20{tl_q[11]}}, tl_q};
      3'd3: prdata = {16'd0, uvlev_q};
      3'd4: prdata = {16'd0, nil_q};
      3'd5: prdata = {16'd0, amax_q};
      3'd6: prdata = {12'd0, win_q};
      3'd7: prdata = {12'd0, tmo_q};
      default: prdata = '0;
    endcase
  end

  // state
  logic [2:0] st_q;
  logic [1:0] phase_q;
  logic [15:0] prev_q;
  logic [TIME_BITS-1:0] settle_q, stable_q;
  logic stab_run_q;
  logic [15:0] maxv_q, minv_q, maxc_q, minc_q;
  logic signed [11:0] maxt_q, mint_q;
  logic [SumBits-1:0] sumv_q, sumc_q;
  logic signed [SumBits-1:0] sumt_q;
  logic [COUNT_BITS-1:0] cnt_q;
  // latched input word
  logic [2:0] op_q;
  logic [15:0] v_q, c_q, dt_q;
  logic signed [11:0] t_q;
  // report
  logic [1:0] dsel_q;
  logic [15:0] av_q, ac_q;
  logic signed [11:0] at_q;
  logic [2:0] fault_q;

  // divider
  logic div_start, div_done;
  logic [SumBits-1:0] div_num, div_quot;
  logic neg_t;

  assign neg_t = sumt_q[SumBits-1];
  always_comb begin
    unique case (dsel_q)
      2'd0: div_num = sumv_q;
      2'd1: div_num = sumc_q;
      default: div_num = neg_t ? SumBits'(-sumt_q) : sumt_q;
    endcase
  end

  pos_divider #(.NumBits(SumBits), .DenBits(COUNT_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(cnt_q),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign div_start   = (st_q == S_DIV);

  // time arithmetic
  logic [TIME_BITS:0] settle_sum, stable_sum;
  logic [TIME_BITS-1:0] settle_new, stable_new;
  logic [15:0] diff, vlim;
  logic stable_hit;

  assign settle_sum = {1'b0, settle_q} + (TIME_BITS+1)'(dt_q);
  assign stable_sum = {1'b0, stable_q} + (TIME_BITS+1)'(dt_q);
  assign settle_new = settle_sum[TIME_BITS] ? TimeMax : settle_sum[TIME_BITS-1:0];
  assign stable_new = stable_sum[TIME_BITS] ? TimeMax : stable_sum[TIME_BITS-1:0];
  assign diff = (v_q > prev_q) ? v_q - prev_q : prev_q - v_q;
  assign stable_hit = diff < 16'(StableBandMv);
  assign vlim = (uvl_q < amax_q) ? uvl_q : amax_q;

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; phase_q <= PH_OFF; prev_q <= '0;
      settle_q <= '0; stable_q <= '0; stab_run_q <= 1'b0;
      maxv_q <= 16'd0; minv_q <= 16'hFFFF; maxc_q <= 16'd0; minc_q <= 16'hFFFF;
      maxt_q <= -12'sd1000; mint_q <= 12'sd2000;
      sumv_q <= '0; sumc_q <= '0; sumt_q <= '0; cnt_q <= '0;
      fault_q <= FLT_NONE; dsel_q <= '0;
      av_q <= '0; ac_q <= '0; at_q <= '0;
      op_q <= '0; v_q <= '0; c_q <= '0; dt_q <= '0; t_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: if (in_valid_i) begin
          op_q <= operation_i; v_q <= voltage_mv_i; c_q <= current_ma_i;
          t_q <= temperature_dc_i; dt_q <= delta_us_i;
          fault_q <= FLT_NONE; av_q <= '0; ac_q <= '0; at_q <= '0;
          st_q <= S_EXEC;
        end
        S_EXEC: begin
          // a report with samples goes on to the divider
          st_q <= (op_q == OP_REPORT && cnt_q != '0) ? S_DIV : S_OUT;
          unique case (op_q)
            OP_SAMPLE: begin
              if (phase_q == PH_SOFT) begin
                settle_q <= settle_new;
                if (v_q > amax_q) begin
                  fault_q <= FLT_ABS_OV; phase_q <= PH_OFF; stab_run_q <= 1'b0;
                end else begin
                  prev_q <= v_q;
                  if (stable_hit && stab_run_q && (TIME_BITS+1)'(stable_new) >
                      (TIME_BITS+1)'(win_q)) begin
                    stable_q <= stable_new; stab_run_q <= 1'b0;
                    if (v_q < nil_q) begin
                      fault_q <= FLT_NO_INPUT; phase_q <= PH_OFF;
                    end else if (v_q < uvlev_q) begin
                      fault_q <= FLT_UV; phase_q <= PH_OFF;
                    end else begin
                      phase_q <= PH_RUN;
                      maxv_q <= 16'd0; minv_q <= 16'hFFFF;
                      maxc_q <= 16'd0; minc_q <= 16'hFFFF;
                      maxt_q <= -12'sd1000; mint_q <= 12'sd2000;
                      sumv_q <= '0; sumc_q <= '0; sumt_q <= '0; cnt_q <= '0;
                    end
                  end else begin
                    if (stable_hit) stable_q <= stab_run_q ? stable_new : '0;
                    if ((TIME_BITS+1)'(settle_new) > (TIME_BITS+1)'(tmo_q)) begin
                      fault_q <= FLT_TIMEOUT; phase_q <= PH_OFF; stab_run_q <= 1'b0;
                    end else begin
                      stab_run_q <= stable_hit;
                    end
                  end
                end
              end else if (phase_q == PH_RUN) begin
                priority if (v_q > vlim) begin
                  fault_q <= FLT_OV; phase_q <= PH_OFF; stab_run_q <= 1'b0;
                end else if (v_q < uvlev_q) begin
                  fault_q <= FLT_UV; phase_q <= PH_OFF; stab_run_q <= 1'b0;
                end else if (c_q > cl_q) begin
                  fault_q <= FLT_OC; phase_q <= PH_OFF; stab_run_q <= 1'b0;
                end else if (t_q > tl_q) begin
                  fault_q <= FLT_OT; phase_q <= PH_OFF; stab_run_q <= 1'b0;
                end else begin
                  if (v_q > maxv_q) maxv_q <= v_q;
                  if (v_q < minv_q) minv_q <= v_q;
                  if (c_q > maxc_q) maxc_q <= c_q;
                  if (c_q < minc_q) minc_q <= c_q;
                  if (t_q > maxt_q) maxt_q <= t_q;
                  if (t_q < mint_q) mint_q <= t_q;
                  if (cnt_q != CountMax) begin
                    sumv_q <= sumv_q + SumBits'(v_q);
                    sumc_q <= sumc_q + SumBits'(c_q);
                    sumt_q <= sumt_q + SumBits'(t_q);
                    cnt_q <= cnt_q + 1'b1;
                  end
                end
              end
            end
            OP_ENABLE: if (phase_q == PH_OFF) begin
              phase_q <= PH_SOFT; prev_q <= v_q; settle_q <= '0;
              stable_q <= '0; stab_run_q <= 1'b0;
            end
            OP_DISABLE: begin
              phase_q <= PH_OFF; stab_run_q <= 1'b0;
            end
            OP_CLEAR: begin
              maxv_q <= 16'd0; minv_q <= 16'hFFFF;
              maxc_q <= 16'd0; minc_q <= 16'hFFFF;
              maxt_q <= -12'sd1000; mint_q <= 12'sd2000;
              sumv_q <= '0; sumc_q <= '0; sumt_q <= '0; cnt_q <= '0;
            end
            OP_REPORT: dsel_q <= 2'd0;
            default: ;
          endcase
        end
        S_DIV: st_q <= S_WAIT;
        S_WAIT: if (div_done) begin
          unique case (dsel_q)
            2'd0: begin av_q <= div_quot[15:0]; dsel_q <= 2'd1; st_q <= S_DIV; end
            2'd1: begin ac_q <= div_quot[15:0]; dsel_q <= 2'd2; st_q <= S_DIV; end
            default: begin
              at_q <= neg_t ? 12'(-div_quot[11:0]) : div_quot[11:0];
              st_q <= S_OUT;
            end
          endcase
        end
        S_OUT: if (!out_stall_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign output_enabled_o = (phase_q != PH_OFF);
  assign fault_code_o = fault_q;
  assign vmax_o = maxv_q;
  assign vmin_o = minv_q;
  assign vmean_o = av_q;
  assign imax_o = maxc_q;
  assign imin_o = minc_q;
  assign imean_o = ac_q;
  assign tmax_o = maxt_q;
  assign tmin_o = mint_q;
  assign tmean_o = at_q;
  assign sample_count_o = (COUNT_BITS > 20 && (cnt_q >> 20) != '0) ? 20'hFFFFF :
                          20'(cnt_q);
endmodule

// ----- hdl/pos_divider.sv -----
// ----------------------------------------------------------------------------
// pos_divider
// Shared restoring divider, one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module pos_divider #(
  parameter int unsigned NumBits = 36,
  parameter int unsigned DenBits = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenBits:0]   trial;

  // one shift/subtract step
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the power output supervisor. A scoreboard class
// tracks the supervisor state, works out the result word for every accepted
// input word and compares it field by field with the result that comes out.
// The run covers directed soft-start, fault and statistics cases and then
// random sequences under several register settings and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pos_pkg::*;

  localparam longint TimeMax  = (64'd1 << 20) - 1;
  localparam longint CountMax = (64'd1 << 20) - 1;

  typedef struct {
    logic        en;
    logic [2:0]  fault;
    logic [15:0] maxv, minv, avgv, maxc, minc, avgc;
    logic [11:0] maxt, mint, avgt;
    logic [19:0] cnt;
  } result_t;

  // Scoreboard: supervisor state, expected result words and mismatch count
  class supervisor_sb;
    int          errors;
    result_t     expected_q[$];
    longint      uvl, cl, tl, uvlev, nilev, absmax, win, tmo;
    logic [1:0]  ph;
    longint      prev_v, settle_el, stable_el;
    bit          stable_run;
    longint      ext[6];
    longint      sums[3];
    longint      count;

    function new();
      errors = 0;
      uvl = 17000; cl = 20000; tl = 900; uvlev = 4500; nilev = 1000;
      absmax = 18000; win = 5000; tmo = 100000;
      ph = PH_OFF; prev_v = 0; settle_el = 0; stable_el = 0; stable_run = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      ext[0] = 0; ext[1] = 65535; ext[2] = 0; ext[3] = 65535;
      ext[4] = -1000; ext[5] = 2000;
      sums[0] = 0; sums[1] = 0; sums[2] = 0; count = 0;
    endfunction

    function void set_reg(int idx, longint val);
      case (idx)
        0: uvl = val & 16'hFFFF;
        1: cl = val & 16'hFFFF;
        2: tl = longint'($signed(val[11:0]));
        3: uvlev = val & 16'hFFFF;
        4: nilev = val & 16'hFFFF;
        5: absmax = val & 16'hFFFF;
        6: win = val & 20'hFFFFF;
        7: tmo = val & 20'hFFFFF;
        default: ;
      endcase
    endfunction

    function void switch_off();
      ph = PH_OFF; stable_run = 0;
    endfunction

    function longint sat(longint a, longint b);
      return (a + b > TimeMax) ? TimeMax : a + b;
    endfunction

    function logic [2:0] soft_sample(longint v, longint dt);
      longint diff;
      bit settled;
      diff = (v > prev_v) ? v - prev_v : prev_v - v;
      settled = 0;
      settle_el = sat(settle_el, dt);
      if (v > absmax) begin
        switch_off(); return FLT_ABS_OV;
      end
      if (diff < StableBandMv) begin
        if (!stable_run) begin
          stable_run = 1; stable_el = 0;
        end else begin
          stable_el = sat(stable_el, dt);
          if (stable_el > win) settled = 1;
        end
      end else begin
        stable_run = 0;
      end
      prev_v = v;
      if (settled) begin
        if (v < nilev) begin
          switch_off(); return FLT_NO_INPUT;
        end
        if (v < uvlev) begin
          switch_off(); return FLT_UV;
        end
        clear_stats(); stable_run = 0; ph = PH_RUN;
        return FLT_NONE;
      end
      if (settle_el > tmo) begin
        switch_off(); return FLT_TIMEOUT;
      end
      return FLT_NONE;
    endfunction

    function logic [2:0] run_sample(longint v, longint c, longint t);
      longint vlim;
      vlim = (uvl < absmax) ? uvl : absmax;
      if (v > vlim) begin switch_off(); return FLT_OV; end
      if (v < uvlev) begin switch_off(); return FLT_UV; end
      if (c > cl) begin switch_off(); return FLT_OC; end
      if (t > tl) begin switch_off(); return FLT_OT; end
      if (v > ext[0]) ext[0] = v;
      if (v < ext[1]) ext[1] = v;
      if (c > ext[2]) ext[2] = c;
      if (c < ext[3]) ext[3] = c;
      if (t > ext[4]) ext[4] = t;
      if (t < ext[5]) ext[5] = t;
      if (count < CountMax) begin
        sums[0] += v; sums[1] += c; sums[2] += t; count++;
      end
      return FLT_NONE;
    endfunction

    // Accepted input word: advance the state and queue the expected result
    function void note_word(logic [2:0] op, logic [15:0] vi, logic [15:0] ci,
                            logic signed [11:0] ti, logic [15:0] di);
      result_t r;
      longint v, c, t, dt, av, ac, at;
      v = vi; c = ci; t = ti; dt = di;
      r.fault = FLT_NONE; av = 0; ac = 0; at = 0;
      case (op)
        OP_SAMPLE: begin
          if (ph == PH_SOFT) r.fault = soft_sample(v, dt);
          else if (ph == PH_RUN) r.fault = run_sample(v, c, t);
        end
        OP_ENABLE: begin
          if (ph == PH_OFF) begin
            ph = PH_SOFT; prev_v = v; settle_el = 0; stable_el = 0; stable_run = 0;
          end
        end
        OP_DISABLE: switch_off();
        OP_CLEAR: clear_stats();
        OP_REPORT: begin
          if (count != 0) begin
            av = sums[0] / count; ac = sums[1] / count; at = sums[2] / count;
          end
        end
        default: ;
      endcase
      r.en = (ph != PH_OFF);
      r.maxv = ext[0][15:0]; r.minv = ext[1][15:0]; r.avgv = av[15:0];
      r.maxc = ext[2][15:0]; r.minc = ext[3][15:0]; r.avgc = ac[15:0];
      r.maxt = ext[4][11:0]; r.mint = ext[5][11:0]; r.avgt = at[11:0];
      r.cnt = (count > 20'hFFFFF) ? 20'hFFFFF : count[19:0];
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task cmp(string what, longint got, longint want);
      if (got != want) report_mismatch(what, got, want);
    endtask

    // Accepted result word: compare with the oldest expectation
    task check_word(result_t g);
      result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result word", 0, 0);
        return;
      end
      e = expected_q.pop_front();
      cmp("output_enabled", g.en, e.en);
      cmp("fault_code", g.fault, e.fault);
      cmp("vmax", g.maxv, e.maxv);
      cmp("vmin", g.minv, e.minv);
      cmp("vmean", g.avgv, e.avgv);
      cmp("imax", g.maxc, e.maxc);
      cmp("imin", g.minc, e.minc);
      cmp("imean", g.avgc, e.avgc);
      cmp("tmax", g.maxt, e.maxt);
      cmp("tmin", g.mint, e.mint);
      cmp("tmean", g.avgt, e.avgt);
      cmp("sample_count", g.cnt, e.cnt);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [2:0] operation_i = '0;
  logic [15:0] voltage_mv_i = '0, current_ma_i = '0, delta_us_i = '0;
  logic signed [11:0] temperature_dc_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic output_enabled_o;
  logic [2:0] fault_code_o;
  logic [15:0] vmax_o, vmin_o, vmean_o;
  logic [15:0] imax_o, imin_o, imean_o;
  logic signed [11:0] tmax_o, tmin_o, tmean_o;
  logic [19:0] sample_count_o;

  power_output_supervisor_core dut (.*);

  supervisor_sb sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  bit recv_hold = 0;
  int items_sent = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Receiver stall, with a long hold-off window
  always @(posedge clk_i)
    out_stall_i <= recv_hold ? 1'b1 : ($urandom_range(99) < recv_idle);

  initial begin
    repeat (300) @(posedge clk_i);
    recv_hold = 1;
    repeat (400) @(posedge clk_i);
    recv_hold = 0;
  end

  // Both handshakes sampled mid-cycle; the word moves on the next rising edge
  always @(negedge clk_i) begin
    result_t g;
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_word(operation_i, voltage_mv_i, current_ma_i, temperature_dc_i, delta_us_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      g.en = output_enabled_o; g.fault = fault_code_o;
      g.maxv = vmax_o; g.minv = vmin_o; g.avgv = vmean_o;
      g.maxc = imax_o; g.minc = imin_o; g.avgc = imean_o;
      g.maxt = tmax_o; g.mint = tmin_o;
      g.avgt = tmean_o; g.cnt = sample_count_o;
      sb.check_word(g);
    end
  end

  task send(logic [2:0] op, int v, int c, int t, int d);
    bit ok;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    operation_i <= op;
    voltage_mv_i <= v[15:0];
    current_ma_i <= c[15:0];
    temperature_dc_i <= t[11:0];
    delta_us_i <= d[15:0];
    do begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
    end while (!ok);
    items_sent++;
  endtask

  task apb_write(int idx, int val);
    bit ok;
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 5'(idx * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do begin
      @(negedge clk_i);
      ok = pready;
      @(posedge clk_i);
    end while (!ok);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task drain();
    in_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Register sets: working, widest, narrowest, mixed with capped voltage limit
  task apply_setting(int k);
    int vals[8];
    case (k)
      0: vals = '{12000, 15000, 600, 4500, 1000, 13000, 200, 3000};
      1: vals = '{65535, 65535, 2000, 0, 0, 65535, 1048575, 1048575};
      2: vals = '{0, 0, -1000, 0, 0, 0, 0, 0};
      default: vals = '{20000, 3000, -200, 8000, 6000, 16000, 1000, 20000};
    endcase
    drain();
    for (int i = 0; i < 8; i++) apb_write(i, vals[i]);
  endtask

  function int clampv(int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  // One enable / soft start / run / stop sequence with random content
  task random_sequence();
    int lo, hi, target, n;
    int v, c, t, r;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(8, 1))
        send(3'($urandom_range(7)), $urandom_range(65535), $urandom_range(65535),
             $urandom_range(3000) - 1000, $urandom_range(65535));
      return;
    end
    hi = int'((sb.uvl < sb.absmax) ? sb.uvl : sb.absmax);
    lo = int'(sb.uvlev);
    if (lo > hi) lo = hi;
    target = (lo + hi) / 2 + $urandom_range(200) - 100;
    if ($urandom_range(7) == 0) target = $urandom_range(65535);
    send(OP_ENABLE, clampv(target), $urandom_range(65535), $urandom_range(3000) - 1000,
         $urandom_range(65535));
    n = $urandom_range(12, 2);
    repeat (n) begin
      v = ($urandom_range(9) == 0) ? $urandom_range(65535) : clampv(target + $urandom_range(98) - 49);
      send(OP_SAMPLE, v, $urandom_range(65535), $urandom_range(3000) - 1000,
           $urandom_range(9) == 0 ? $urandom_range(65535) : $urandom_range(300));
    end
    repeat ($urandom_range(25, 5)) begin
      r = $urandom_range(99);
      if (r < 8) send(OP_REPORT, $urandom_range(65535), 0, 0, $urandom_range(65535));
      else if (r < 11) send(OP_CLEAR, 0, $urandom_range(65535), 0, 0);
      else if (r < 13) send(3'($urandom_range(7, 5)), $urandom_range(65535), 0, 0, 0);
      else if (r < 20)
        send(OP_SAMPLE, $urandom_range(65535), $urandom_range(65535),
             $urandom_range(3000) - 1000, $urandom_range(65535));
      else begin
        v = $urandom_range(hi, lo);
        c = $urandom_range(sb.cl);
        t = $urandom_range(sb.tl + 1000) - 1000;
        send(OP_SAMPLE, v, c, t, $urandom_range(1000));
      end
    end
    send(OP_REPORT, 0, 0, 0, 0);
    if ($urandom_range(1)) send(OP_DISABLE, $urandom_range(65535), 0, 0, 0);
  endtask

  task directed();
    send(OP_SAMPLE, 9000, 100, 100, 50);       // sample while off is ignored
    send(OP_REPORT, 0, 0, 0, 0);               // report with zero count
    send(3'(5), 1, 2, 3, 4);
    send(3'(7), 65535, 65535, 2000, 65535);
    send(OP_ENABLE, 10000, 0, 0, 65535);
    send(OP_ENABLE, 200, 0, 0, 0);             // already on: ignored
    send(OP_SAMPLE, 10300, 0, 0, 10);          // jump: unstable
    send(OP_SAMPLE, 10320, 0, 0, 10);          // stable timer starts
    send(OP_SAMPLE, 10330, 0, 0, 150);
    send(OP_SAMPLE, 10340, 0, 0, 100);         // window passed: running
    send(OP_SAMPLE, 10000, 5000, 250, 10);
    send(OP_SAMPLE, 4500, 0, -1000, 10);
    send(OP_SAMPLE, 12000, 15000, 600, 10);
    send(OP_REPORT, 0, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0, 0);
    send(OP_SAMPLE, 12001, 0, 0, 0);           // over user limit
    send(OP_ENABLE, 500, 0, 0, 0);
    repeat (3) send(OP_SAMPLE, 500, 0, 0, 150); // no input supply
    send(OP_ENABLE, 3000, 0, 0, 0);
    repeat (3) send(OP_SAMPLE, 3000, 0, 0, 150); // undervoltage after settling
    send(OP_ENABLE, 5000, 0, 0, 0);
    send(OP_SAMPLE, 13001, 0, 0, 0);           // absolute maximum
    send(OP_ENABLE, 5000, 0, 0, 0);
    send(OP_SAMPLE, 6000, 0, 0, 3001);         // settle timeout
    send(OP_DISABLE, 0, 0, 0, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    apply_setting(0);
    send_idle = 23; recv_idle = 49;
    directed();
    for (int p = 0; p < 6; p++) begin
      apply_setting((p == 0) ? 0 : p % 4);
      send_idle = (p < 2) ? 23 : (p < 4) ? 49 : 0;
      recv_idle = (p < 2) ? 49 : (p < 4) ? 23 : 0;
      while (items_sent < 30 + 115 * (p + 1)) random_sequence();
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Test completed successfully");
    else begin
      if (sb.expected_q.size() != 0)
        $display("MISMATCH %0d result words never arrived", sb.expected_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
